// ===== rtl/ffp_pkg.sv =====
// ----------------------------------------------------------------------------
// ffp_pkg: shared definitions for the first-fit frame packer
// Frame geometry, field widths and the fit result passed between modules.
// ----------------------------------------------------------------------------
package ffp_pkg;

  localparam int FRAME_COUNT_DEF = 4;
  localparam int FRAME_BYTES     = 8;
  localparam int LEN_W           = 4;
  localparam int FILL_W          = 4;
  localparam int OFS_W           = 3;
  localparam int IDX_OUT_W       = 2;
  localparam int USED_OUT_W      = 3;
  localparam int IN_DATA_W       = 8;
  localparam int OUT_DATA_W      = 8;

  typedef struct packed {
    logic              hit;
    logic [OFS_W-1:0]  offset;
    logic [FILL_W-1:0] new_fill;
  } fit_t;

endpackage

// ===== rtl/ffp_fit.sv =====
// ----------------------------------------------------------------------------
// ffp_fit: first-fit frame selection
// Compares the item length against every frame's free space in parallel and
// picks the lowest-numbered frame that can take it.
// ----------------------------------------------------------------------------
module ffp_fit #(
  parameter int FRAME_COUNT = ffp_pkg::FRAME_COUNT_DEF,
  parameter int IDX_W       = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
  input  logic [ffp_pkg::LEN_W-1:0]                   item_len_i,
  input  logic                                        new_set_i,
  input  logic [FRAME_COUNT-1:0][ffp_pkg::FILL_W-1:0] fill_i,
  output logic [IDX_W-1:0]                            pick_o,
  output ffp_pkg::fit_t                               fit_o
);
  import ffp_pkg::*;

  logic [FRAME_COUNT-1:0][FILL_W-1:0] eff_fill;
  logic [FRAME_COUNT-1:0]             fits;
  logic                               len_ok;
  logic [FILL_W-1:0]                  sel_fill;

  assign len_ok = (item_len_i != '0) && (item_len_i <= LEN_W'(FRAME_BYTES));

  always_comb begin
    for (int f = 0; f < FRAME_COUNT; f++) begin
      eff_fill[f] = new_set_i ? '0 : fill_i[f];
      fits[f]     = len_ok &&
                    (({1'b0, eff_fill[f]} + {1'b0, item_len_i}) <=
                     (FILL_W + 1)'(FRAME_BYTES));
    end
  end

  always_comb begin
    pick_o   = '0;
    sel_fill = '0;
    for (int f = FRAME_COUNT - 1; f >= 0; f--) begin
      if (fits[f]) begin
        pick_o   = IDX_W'(f);
        sel_fill = eff_fill[f];
      end
    end
  end

  assign fit_o.hit      = |fits;
  assign fit_o.offset   = fit_o.hit ? sel_fill[OFS_W-1:0] : '0;
  assign fit_o.new_fill = sel_fill + item_len_i;

endmodule

// ===== rtl/ffp_frames.sv =====
// ----------------------------------------------------------------------------
// ffp_frames: frame fill levels and open-frame count
// Holds the per-frame byte counts and updates them when an item is placed or
// a new mapping set clears them.
// ----------------------------------------------------------------------------
module ffp_frames #(
  parameter int FRAME_COUNT = ffp_pkg::FRAME_COUNT_DEF,
  parameter int IDX_W       = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1,
  parameter int CNT_W       = $clog2(FRAME_COUNT + 1)
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        upd_i,
  input  logic                                        new_set_i,
  input  logic [IDX_W-1:0]                            pick_i,
  input  ffp_pkg::fit_t                               fit_i,
  output logic [FRAME_COUNT-1:0][ffp_pkg::FILL_W-1:0] fill_o,
  output logic [CNT_W-1:0]                            open_nxt_o
);
  import ffp_pkg::*;

  logic [FRAME_COUNT-1:0][FILL_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0]                   open_r, open_nxt, open_clr;

  always_comb begin
    for (int f = 0; f < FRAME_COUNT; f++) begin
      fill_nxt[f] = new_set_i ? '0 : fill_r[f];
      if (fit_i.hit && (pick_i == IDX_W'(f))) begin
        fill_nxt[f] = fit_i.new_fill;
      end
    end
    open_clr = new_set_i ? '0 : open_r;
    open_nxt = open_clr;
    if (fit_i.hit && (CNT_W'(pick_i) >= open_clr)) begin
      open_nxt = CNT_W'(pick_i) + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      open_r <= '0;
    end else if (upd_i) begin
      fill_r <= fill_nxt;
      open_r <= open_nxt;
    end
  end

  assign fill_o     = fill_r;
  assign open_nxt_o = open_nxt;

endmodule

// ===== rtl/first_fit_frame_packer.sv =====
// ----------------------------------------------------------------------------
// first_fit_frame_packer: first-fit packing of objects into 8-byte frames
//
//   Channel  Direction  tdata                      tuser
//   in_      slave      item_length                new_set
//   out_     master     frame_index, byte_offset,  overflow
//                       frames_used
//
// One word per cycle sustained while the output is not stalled: the input register
// feeds the parallel fit compare and priority pick, which load the result
// register and the frame state in the same cycle. Reset empties every frame.
// A stalled output holds its word while the input register can still take
// one more word.
// ----------------------------------------------------------------------------
module first_fit_frame_packer #(
  parameter int FRAME_COUNT = ffp_pkg::FRAME_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ffp_pkg::IN_DATA_W-1:0]    in_tdata,   // [3:0] item_length
  input  logic                             in_tuser,   // [0] new_set
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ffp_pkg::OUT_DATA_W-1:0]   out_tdata,  // [1:0] frame_index,
                                                       // [4:2] byte_offset,
                                                       // [7:5] frames_used
  output logic                             out_tuser   // [0] overflow
);
  import ffp_pkg::*;

  localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CNT_W = $clog2(FRAME_COUNT + 1);

  logic                               in_v_r;
  logic [LEN_W-1:0]                   len_r;
  logic                               new_set_r;
  logic                               out_v_r;
  logic [OUT_DATA_W-1:0]              odata_r;
  logic                               oflow_r;
  logic                               adv;
  logic [IDX_W-1:0]                   pick;
  fit_t                               fit;
  logic [FRAME_COUNT-1:0][FILL_W-1:0] fill;
  logic [CNT_W-1:0]                   open_nxt;
  logic [CNT_W+2:0]                   open_ext;
  logic [IDX_W+1:0]                   pick_ext;
  logic [IDX_OUT_W-1:0]               idx_out;
  logic [USED_OUT_W-1:0]              used_out;

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      len_r     <= in_tdata[LEN_W-1:0];
      new_set_r <= in_tuser;
    end
  end

  ffp_fit #(
    .FRAME_COUNT (FRAME_COUNT),
    .IDX_W       (IDX_W)
  ) u_fit (
    .item_len_i (len_r),
    .new_set_i  (new_set_r),
    .fill_i     (fill),
    .pick_o     (pick),
    .fit_o      (fit)
  );

  ffp_frames #(
    .FRAME_COUNT (FRAME_COUNT),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_frames (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd_i      (adv),
    .new_set_i  (new_set_r),
    .pick_i     (pick),
    .fit_i      (fit),
    .fill_o     (fill),
    .open_nxt_o (open_nxt)
  );

  assign open_ext = (CNT_W + 3)'(open_nxt);
  assign used_out = (open_ext > (CNT_W + 3)'(7)) ? USED_OUT_W'(7)
                                                 : open_ext[USED_OUT_W-1:0];
  assign pick_ext = {2'b00, pick};
  assign idx_out  = fit.hit ? pick_ext[IDX_OUT_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      odata_r <= {used_out, fit.offset, idx_out};
      oflow_r <= !fit.hit;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = oflow_r;

endmodule

// ===== test/first_fit_frame_packer_test.sv =====
// ----------------------------------------------------------------------------
// first_fit_frame_packer_test: self-checking bench for the frame packer
// Objects of random length go in on the input stream. A model of the first-fit
// placement predicts each output word, and the bench compares them field by
// field. The run covers directed corner cases, random mapping sets, and
// phases of sender idling and receiver stalls, including one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module first_fit_frame_packer_test;
  import ffp_pkg::*;

  localparam int LIMIT      = 400000;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = 20;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             new_set;
  } object_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]  frame_index;
    logic [OFS_W-1:0]      byte_offset;
    logic [USED_OUT_W-1:0] frames_used;
    logic                  overflow;
  } placement_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  object_t    object_q[$];
  placement_t placement_q[$];
  logic [FILL_W-1:0] fill_level[FRAME_COUNT_DEF];
  int   frames_open;
  logic in_hs = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_asked = 0;
  int   hold_given = 0;
  int   hold_left = 0;
  int   queued_total = 0;
  int   accepted_total = 0;
  int   word_cnt = 0;
  int   cycle_cnt = 0;
  int   errors = 0;

  first_fit_frame_packer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic placement_t place_object(input logic [LEN_W-1:0] len,
                                              input logic clear);
    placement_t res;
    int pick;
    pick = -1;
    res = '0;
    if (clear) begin
      for (int f = 0; f < FRAME_COUNT_DEF; f++) fill_level[f] = '0;
      frames_open = 0;
    end
    if (len >= 1 && len <= FRAME_BYTES) begin
      for (int f = 0; f < FRAME_COUNT_DEF; f++) begin
        if (pick < 0 && int'(fill_level[f]) + int'(len) <= FRAME_BYTES) pick = f;
      end
    end
    if (pick >= 0) begin
      res.frame_index = pick[IDX_OUT_W-1:0];
      res.byte_offset = fill_level[pick][OFS_W-1:0];
      fill_level[pick] = fill_level[pick] + len;
      if (pick >= frames_open) frames_open = pick + 1;
    end
    res.overflow = (pick < 0);
    res.frames_used = (frames_open > 7) ? 3'd7 : frames_open[USED_OUT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("Mismatch on output word %0d: %s is %0d, expected %0d",
             word_cnt, field, got, want);
    errors++;
  endtask

  task automatic add_object(input int len, input bit ns);
    object_t obj;
    obj.len = len[LEN_W-1:0];
    obj.new_set = ns;
    object_q.insert(object_q.size(), obj);
    queued_total++;
  endtask

  // Mostly well-formed mapping sets of one to twelve objects that start with
  // new_set and can run out of frames, with some bad lengths mixed in.
  task automatic add_random_sets(input int target);
    int n;
    int set_len;
    bit ns;
    n = 0;
    while (n < target) begin
      set_len = $urandom_range(1, 12);
      for (int i = 0; i < set_len; i++) begin
        ns = (i == 0) ? ($urandom_range(99) >= 10) : ($urandom_range(99) < 3);
        if ($urandom_range(99) < 6) begin
          if ($urandom_range(7) == 0) add_object(0, ns);
          else add_object($urandom_range(9, 15), ns);
        end else if ($urandom_range(3) == 0) begin
          add_object($urandom_range(1, 3), ns);
        end else begin
          add_object($urandom_range(1, 8), ns);
        end
        n++;
      end
    end
  endtask

  task automatic wait_drained;
    wait (accepted_total == queued_total && placement_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  always @(negedge clk) begin
    object_t nxt;
    logic give;
    if (rst_n && (!in_tvalid || in_hs)) begin
      give = object_q.size() != 0 && $urandom_range(99) >= send_idle_pct;
      if (give) begin
        nxt = object_q[0];
        object_q.delete(0);
        in_tdata <= {{(IN_DATA_W-LEN_W){1'b0}}, nxt.len};
        in_tuser <= nxt.new_set;
      end
      in_tvalid <= give;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_asked != hold_given) begin
      hold_given++;
      hold_left = HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    placement_t want;
    placement_t got;
    cycle_cnt++;
    in_hs <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        placement_q.insert(placement_q.size(),
                           place_object(in_tdata[LEN_W-1:0], in_tuser));
        accepted_total++;
      end
      if (out_tvalid && out_tready) begin
        got.frame_index = out_tdata[1:0];
        got.byte_offset = out_tdata[4:2];
        got.frames_used = out_tdata[7:5];
        got.overflow = out_tuser;
        if (placement_q.size() == 0) begin
          $display("Unexpected output word %0d: tdata %h tuser %b",
                   word_cnt, out_tdata, out_tuser);
          errors++;
        end else begin
          want = placement_q[0];
          placement_q.delete(0);
          if (got.frame_index !== want.frame_index)
            report_mismatch("frame_index", got.frame_index, want.frame_index);
          if (got.byte_offset !== want.byte_offset)
            report_mismatch("byte_offset", got.byte_offset, want.byte_offset);
          if (got.frames_used !== want.frames_used)
            report_mismatch("frames_used", got.frames_used, want.frames_used);
          if (got.overflow !== want.overflow)
            report_mismatch("overflow", got.overflow, want.overflow);
        end
        word_cnt++;
      end
    end
    if (cycle_cnt >= LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int f = 0; f < FRAME_COUNT_DEF; f++) fill_level[f] = '0;
    frames_open = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Fill all four frames with full objects, then run out of room.
    add_object(8, 1'b0);
    add_object(8, 1'b0);
    add_object(8, 1'b0);
    add_object(8, 1'b0);
    add_object(1, 1'b0);
    // A rejected length still clears the set.
    add_object(0, 1'b1);
    add_object(1, 1'b0);
    add_object(7, 1'b0);
    add_object(2, 1'b0);
    add_object(6, 1'b0);
    add_object(9, 1'b0);
    add_object(15, 1'b0);
    add_object(3, 1'b0);
    add_object(5, 1'b0);
    add_object(4, 1'b0);
    add_object(4, 1'b0);
    add_object(4, 1'b0);
    add_object(8, 1'b0);
    add_object(12, 1'b1);
    add_object(3, 1'b1);
    add_object(8, 1'b0);
    add_object(5, 1'b0);
    wait_drained();

    hold_asked++;
    add_random_sets(340);
    wait_drained();

    send_idle_pct = 88;
    add_random_sets(340);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 88;
    add_random_sets(340);
    wait_drained();

    send_idle_pct = 6;
    recv_stall_pct = 6;
    add_random_sets(340);
    wait_drained();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
